>>> rtl/dqf_pkg.sv
`timescale 1ns / 1ps
package dqf_pkg;

  localparam int RULES_DEF    = 16;
  localparam int NAME_LEN_DEF = 64;
  localparam int RULE_CHARS   = 64;
  localparam int HDR_BYTES    = 12;

  localparam logic [7:0] LABEL_MAX = 8'd63;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [15:0] QTYPE_A  = 16'd1;

  typedef enum logic [1:0] {
    FN_CHAR = 2'd0,
    FN_ATTR = 2'd1,
    FN_BYTE = 2'd2,
    FN_NONE = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    V_NONE     = 2'd0,
    V_NOMATCH  = 2'd1,
    V_BLOCK    = 2'd2,
    V_REDIRECT = 2'd3
  } verdict_t;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_LEN,
    PH_BODY,
    PH_TYPE_HI,
    PH_TYPE_LO,
    PH_DONE,
    PH_BAD
  } phase_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_RULE,
    BK_LOAD,
    BK_W1,
    BK_EXACT,
    BK_CMPI,
    BK_CMPD,
    BK_OUT
  } bk_state_t;

  typedef struct packed {
    logic [5:0]  len;
    logic        blk;
    logic [31:0] addr;
  } rule_attr_t;

  typedef struct packed {
    logic       txt_en;
    logic       attr_en;
    logic [3:0] idx;
    logic [5:0] pos;
    logic [7:0] ch;
    rule_attr_t attr;
  } rule_wr_t;

  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] ch;
  } name_wr_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] qid;
    logic [7:0]  ncnt;
  } pkt_desc_t;

endpackage

>>> rtl/dqf_ifs.sv
`timescale 1ns / 1ps
interface dqf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [3:0]  rule_index;
  logic [5:0]  char_pos;
  logic [7:0]  byte_value;
  logic [5:0]  rule_length;
  logic        blocked;
  logic [31:0] redirect_addr;
  logic        last;
  modport source (output valid, func, rule_index, char_pos, byte_value, rule_length,
                  blocked, redirect_addr, last, input ready);
  modport sink (input valid, func, rule_index, char_pos, byte_value, rule_length,
                blocked, redirect_addr, last, output ready);
endinterface

interface dqf_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  verdict;
  logic [15:0] txn_id;
  logic [31:0] answer_addr;
  modport source (output valid, verdict, txn_id, answer_addr, input ready);
  modport sink (input valid, verdict, txn_id, answer_addr, output ready);
endinterface

interface dqf_cfg_if;
  logic       valid;
  logic       ready;
  logic [4:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

>>> rtl/dqf_front.sv
`timescale 1ns / 1ps
module dqf_front import dqf_pkg::*; #(
  parameter int RULES    = RULES_DEF,
  parameter int NAME_LEN = NAME_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dqf_in_if.sink    in_if,
  input  logic      hold,
  output rule_wr_t  rule_wr,
  output name_wr_t  name_wr,
  output logic      push,
  output pkt_desc_t desc
);

  localparam int NCW = $clog2(NAME_LEN);

  phase_t           phase_r, phase_nxt;
  logic [3:0]       pos_r, pos_nxt;
  logic [5:0]       lrem_r, lrem_nxt;
  logic [NCW-1:0]   nc_r, nc_nxt;
  logic [15:0]      id_r, id_nxt;
  logic [15:0]      typ_r, typ_nxt;

  logic       acc;
  logic       app;
  logic [7:0] ach;
  logic [7:0] b;

  assign in_if.ready = !hold;
  assign acc = in_if.valid && in_if.ready;
  assign b   = in_if.byte_value;

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    lrem_nxt  = lrem_r;
    nc_nxt    = nc_r;
    id_nxt    = id_r;
    typ_nxt   = typ_r;
    app       = 1'b0;
    ach       = b;
    rule_wr   = '0;
    rule_wr.idx       = in_if.rule_index;
    rule_wr.pos       = in_if.char_pos;
    rule_wr.ch        = b;
    rule_wr.attr.len  = in_if.rule_length;
    rule_wr.attr.blk  = in_if.blocked;
    rule_wr.attr.addr = in_if.redirect_addr;
    name_wr   = '0;
    push      = 1'b0;
    desc      = '0;
    if (acc) begin
      unique case (func_t'(in_if.func))
        FN_CHAR: rule_wr.txt_en  = (11'(in_if.rule_index) < 11'(RULES));
        FN_ATTR: rule_wr.attr_en = (11'(in_if.rule_index) < 11'(RULES));
        FN_NONE: ;
        FN_BYTE: begin
          unique case (phase_r)
            PH_HEADER: begin
              if (pos_r == 4'd0) id_nxt = {b, 8'h00};
              else if (pos_r == 4'd1) id_nxt = {id_r[15:8], b};
              if (pos_r == 4'(HDR_BYTES - 1)) phase_nxt = PH_LEN;
              if (pos_r != 4'hF) pos_nxt = pos_r + 4'd1;
            end
            PH_LEN: begin
              if (b == 8'd0) begin
                phase_nxt = PH_TYPE_HI;
              end else if (b > LABEL_MAX) begin
                phase_nxt = PH_BAD;
              end else begin
                app       = (nc_r != '0);
                ach       = CH_DOT;
                lrem_nxt  = b[5:0];
                phase_nxt = PH_BODY;
              end
            end
            PH_BODY: begin
              app      = 1'b1;
              lrem_nxt = lrem_r - 6'd1;
              if (lrem_nxt == 6'd0) phase_nxt = PH_LEN;
            end
            PH_TYPE_HI: begin
              typ_nxt   = {b, 8'h00};
              phase_nxt = PH_TYPE_LO;
            end
            PH_TYPE_LO: begin
              typ_nxt   = {typ_r[15:8], b};
              phase_nxt = PH_DONE;
            end
            default: ;
          endcase
          if (app && (9'(nc_r) < 9'(NAME_LEN - 1))) begin
            name_wr.en   = 1'b1;
            name_wr.addr = 8'(nc_r);
            name_wr.ch   = ach;
            nc_nxt       = nc_r + 1'b1;
          end
          if (in_if.last) begin
            push      = 1'b1;
            desc.ok   = (phase_nxt == PH_DONE) && (typ_nxt == QTYPE_A);
            desc.qid  = id_nxt;
            desc.ncnt = 8'(nc_nxt);
            phase_nxt = PH_HEADER;
            pos_nxt   = '0;
            lrem_nxt  = '0;
            nc_nxt    = '0;
            id_nxt    = '0;
            typ_nxt   = '0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HEADER;
      pos_r   <= '0;
      lrem_r  <= '0;
      nc_r    <= '0;
      id_r    <= '0;
      typ_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      lrem_r  <= lrem_nxt;
      nc_r    <= nc_nxt;
      id_r    <= id_nxt;
      typ_r   <= typ_nxt;
    end
  end

endmodule

>>> rtl/dqf_fifo.sv
`timescale 1ns / 1ps
module dqf_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty,
  output logic             full
);

  // two entries, slot 0 is the head
  logic [WIDTH-1:0] ent_r [2];
  logic [1:0]       cnt_r, cnt_nxt;

  assign rdata = ent_r[0];
  assign empty = (cnt_r == 2'd0);
  assign full  = (cnt_r == 2'd2);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !full && !(pop && !empty)) cnt_nxt = cnt_r + 2'd1;
    else if (pop && !empty && !(push && !full)) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) cnt_r <= '0;
    else cnt_r <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (pop && !empty) begin
      if (push && cnt_r == 2'd1) ent_r[0] <= wdata;
      else ent_r[0] <= ent_r[1];
    end else if (push && !full) begin
      if (cnt_r == 2'd0) ent_r[0] <= wdata;
      else ent_r[1] <= wdata;
    end
  end

endmodule

>>> rtl/dqf_back.sv
`timescale 1ns / 1ps
module dqf_back import dqf_pkg::*; #(
  parameter int RULES    = RULES_DEF,
  parameter int NAME_LEN = NAME_LEN_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic [4:0] active_rules,
  input  rule_wr_t  rule_wr,
  input  name_wr_t  name_wr,
  input  logic      q_empty,
  input  pkt_desc_t q_head,
  output logic      pop,
  output logic      busy,
  dqf_out_if.source out_if
);

  localparam int NCW = $clog2(NAME_LEN);
  localparam int CW  = $clog2(RULES + 1);
  localparam int RIW = (RULES > 1) ? $clog2(RULES) : 1;
  localparam int TAW = $clog2(RULES * RULE_CHARS);

  logic [7:0]  txt_mem  [RULES * RULE_CHARS];
  rule_attr_t  attr_mem [RULES];
  logic [7:0]  name_mem [NAME_LEN];

  logic [7:0]     txt_q, name_q;
  rule_attr_t     attr_q;
  logic [TAW-1:0] txt_raddr;
  logic [NCW-1:0] name_raddr;
  logic [5:0]     tpos;

  bk_state_t      st_r, st_nxt;
  logic [CW-1:0]  r_r, r_nxt;
  logic [NCW-1:0] nc_r, nc_nxt;
  logic [NCW-1:0] noff_r, noff_nxt;
  logic [5:0]     cnt_r, cnt_nxt;
  logic [5:0]     k_r, k_nxt;
  logic           wild_r, wild_nxt;
  verdict_t       vd_r, vd_nxt;
  logic [15:0]    qid_r, qid_nxt;
  logic [31:0]    ans_r, ans_nxt;

  logic [CW-1:0]  nrules;
  logic [5:0]     sl;

  assign nrules = (11'(active_rules) > 11'(RULES)) ? CW'(RULES) : CW'(active_rules);
  assign sl     = attr_q.len - 6'd2;
  assign busy   = (st_r != BK_IDLE);

  always_ff @(posedge clk) begin
    if (rule_wr.txt_en) txt_mem[TAW'({rule_wr.idx, rule_wr.pos})] <= rule_wr.ch;
    if (rule_wr.attr_en) attr_mem[RIW'(rule_wr.idx)] <= rule_wr.attr;
    if (name_wr.en) name_mem[NCW'(name_wr.addr)] <= name_wr.ch;
    txt_q  <= txt_mem[txt_raddr];
    attr_q <= attr_mem[r_r[RIW-1:0]];
    name_q <= name_mem[name_raddr];
  end

  always_comb begin
    st_nxt   = st_r;
    r_nxt    = r_r;
    nc_nxt   = nc_r;
    noff_nxt = noff_r;
    cnt_nxt  = cnt_r;
    k_nxt    = k_r;
    wild_nxt = wild_r;
    vd_nxt   = vd_r;
    qid_nxt  = qid_r;
    ans_nxt  = ans_r;
    pop      = 1'b0;
    tpos       = k_r + (wild_r ? 6'd2 : 6'd0);
    name_raddr = noff_r + NCW'(k_r);
    unique case (st_r)
      BK_IDLE: begin
        if (!q_empty) begin
          pop     = 1'b1;
          qid_nxt = q_head.qid;
          nc_nxt  = NCW'(q_head.ncnt);
          ans_nxt = '0;
          r_nxt   = '0;
          if (q_head.ok) begin
            st_nxt = BK_RULE;
          end else begin
            vd_nxt = V_NONE;
            st_nxt = BK_OUT;
          end
        end
      end
      BK_RULE: begin
        tpos = 6'd0;
        if (r_r >= nrules) begin
          vd_nxt = V_NOMATCH;
          st_nxt = BK_OUT;
        end else begin
          st_nxt = BK_LOAD;
        end
      end
      BK_LOAD: begin
        tpos = 6'd1;
        if (attr_q.len >= 6'd2 && txt_q == CH_STAR) st_nxt = BK_W1;
        else st_nxt = BK_EXACT;
      end
      BK_W1: begin
        if (txt_q == CH_DOT) begin
          if (9'(nc_r) < 9'(sl)) begin
            r_nxt  = r_r + 1'b1;
            st_nxt = BK_RULE;
          end else begin
            noff_nxt = NCW'(9'(nc_r) - 9'(sl));
            cnt_nxt  = sl;
            wild_nxt = 1'b1;
            k_nxt    = '0;
            st_nxt   = BK_CMPI;
          end
        end else begin
          st_nxt = BK_EXACT;
        end
      end
      BK_EXACT: begin
        if (9'(attr_q.len) != 9'(nc_r)) begin
          r_nxt  = r_r + 1'b1;
          st_nxt = BK_RULE;
        end else begin
          noff_nxt = '0;
          cnt_nxt  = attr_q.len;
          wild_nxt = 1'b0;
          k_nxt    = '0;
          st_nxt   = BK_CMPI;
        end
      end
      BK_CMPI: begin
        if (k_r == cnt_r) begin
          if (attr_q.blk) begin
            vd_nxt = V_BLOCK;
          end else begin
            vd_nxt  = V_REDIRECT;
            ans_nxt = attr_q.addr;
          end
          st_nxt = BK_OUT;
        end else begin
          st_nxt = BK_CMPD;
        end
      end
      BK_CMPD: begin
        if (name_q == txt_q) begin
          k_nxt  = k_r + 6'd1;
          st_nxt = BK_CMPI;
        end else begin
          r_nxt  = r_r + 1'b1;
          st_nxt = BK_RULE;
        end
      end
      BK_OUT: begin
        if (out_if.ready) st_nxt = BK_IDLE;
      end
      default: st_nxt = BK_IDLE;
    endcase
    txt_raddr = TAW'({r_r, tpos});
  end

  assign out_if.valid       = (st_r == BK_OUT);
  assign out_if.verdict     = vd_r;
  assign out_if.txn_id      = qid_r;
  assign out_if.answer_addr = ans_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= BK_IDLE;
    else st_r <= st_nxt;
  end

  always_ff @(posedge clk) begin
    r_r    <= r_nxt;
    nc_r   <= nc_nxt;
    noff_r <= noff_nxt;
    cnt_r  <= cnt_nxt;
    k_r    <= k_nxt;
    wild_r <= wild_nxt;
    vd_r   <= vd_nxt;
    qid_r  <= qid_nxt;
    ans_r  <= ans_nxt;
  end

endmodule

>>> rtl/dns_query_domain_filter.sv
`timescale 1ns / 1ps
// Throughput: rule and packet words at one per cycle while the matcher is idle
//   and the descriptor queue is empty; one packet's rule walk, set by the
//   shared text compare loop, blocks input.
// Reset (rst_n low, synchronous): parser, queue, matcher and active_rules clear;
//   rule and name stores hold stale data until written.
module dns_query_domain_filter import dqf_pkg::*; #(
  parameter int RULES    = RULES_DEF,
  parameter int NAME_LEN = NAME_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  dqf_in_if.sink     in_if,
  dqf_out_if.source  out_if,
  dqf_cfg_if.sink    cfg_if
);

  // number of rules checked; the user writes it only while idle, unenforced
  logic [4:0] active_rules_r, active_rules_nxt;

  rule_wr_t  rule_wr;
  name_wr_t  name_wr;
  pkt_desc_t desc, q_head;
  logic      push, pop, q_empty, q_full, bk_busy;

  assign cfg_if.ready     = 1'b1;
  assign active_rules_nxt = (cfg_if.valid) ? cfg_if.data : active_rules_r;

  always_ff @(posedge clk) begin
    if (!rst_n) active_rules_r <= '0;
    else active_rules_r <= active_rules_nxt;
  end

  // front: parses header, labels and type; writes rule and name stores.
  // It holds off while a packet is queued or being matched, since the
  // matcher reads both stores.
  dqf_front #(.RULES(RULES), .NAME_LEN(NAME_LEN)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_if),
    .hold    (bk_busy || !q_empty || q_full),
    .rule_wr (rule_wr),
    .name_wr (name_wr),
    .push    (push),
    .desc    (desc)
  );

  // packet descriptors between parser and matcher
  dqf_fifo #(.WIDTH($bits(pkt_desc_t))) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (desc),
    .pop   (pop),
    .rdata (q_head),
    .empty (q_empty),
    .full  (q_full)
  );

  // back: walks rules in index order, first match wins
  dqf_back #(.RULES(RULES), .NAME_LEN(NAME_LEN)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .active_rules (active_rules_r),
    .rule_wr      (rule_wr),
    .name_wr      (name_wr),
    .q_empty      (q_empty),
    .q_head       (q_head),
    .pop          (pop),
    .busy         (bk_busy),
    .out_if       (out_if)
  );

endmodule

>>> rtl/dqf_checker.sv
`timescale 1ns / 1ps
module dqf_checker import dqf_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  verdict,
  input logic [31:0] answer_addr
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(verdict) && $stable(answer_addr))
    else $error("result word changed while stalled");

  a_addr_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && verdict != V_REDIRECT |-> answer_addr == 32'd0)
    else $error("answer address set without redirect");

  a_no_take: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while verdict pending");

endmodule

bind dns_query_domain_filter dqf_checker u_dqf_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .verdict     (out_if.verdict),
  .answer_addr (out_if.answer_addr)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps
module testbench;
  import dqf_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // One expected verdict word as the block should return it.
  typedef struct {
    verdict_t    verdict;
    logic [15:0] qid;
    logic [31:0] addr;
  } verdict_word_t;

  // Predicts verdicts from the accepted words and checks the returned ones.
  class verdict_board;
    logic [7:0]  txt [RULES_DEF][RULE_CHARS];
    logic [5:0]  len [RULES_DEF];
    logic        blk [RULES_DEF];
    logic [31:0] redir [RULES_DEF];
    logic [4:0]  active;
    logic [7:0]  name [NAME_LEN_DEF];
    int          ncnt;
    int          pos;
    phase_t      phase;
    int          remain;
    logic [15:0] qid;
    logic [15:0] qtype;
    verdict_word_t pending[$];
    int          errors;

    function void clear_packet();
      ncnt = 0; pos = 0; phase = PH_HEADER; remain = 0; qid = '0; qtype = '0;
    endfunction

    function void add_char(logic [7:0] c);
      if (ncnt < NAME_LEN_DEF - 1) begin
        name[ncnt] = c;
        ncnt++;
      end
    endfunction

    function bit rule_hit(int r);
      int n;
      int sl;
      n = len[r];
      if (n >= 2 && txt[r][0] == CH_STAR && txt[r][1] == CH_DOT) begin
        sl = n - 2;
        if (ncnt < sl) return 0;
        for (int i = 0; i < sl; i++)
          if (name[ncnt - sl + i] != txt[r][2 + i]) return 0;
        return 1;
      end
      if (n != ncnt) return 0;
      for (int i = 0; i < n; i++)
        if (name[i] != txt[r][i]) return 0;
      return 1;
    endfunction

    function void take_byte(logic [7:0] b);
      case (phase)
        PH_HEADER: begin
          if (pos == 0) qid[15:8] = b;
          else if (pos == 1) qid[7:0] = b;
          if (pos == HDR_BYTES - 1) phase = PH_LEN;
        end
        PH_LEN: begin
          if (b == 0) phase = PH_TYPE_HI;
          else if (b > LABEL_MAX) phase = PH_BAD;
          else begin
            if (ncnt > 0) add_char(CH_DOT);
            remain = b;
            phase = PH_BODY;
          end
        end
        PH_BODY: begin
          add_char(b);
          remain = (remain - 1) & 63;
          if (remain == 0) phase = PH_LEN;
        end
        PH_TYPE_HI: begin
          qtype[15:8] = b;
          phase = PH_TYPE_LO;
        end
        PH_TYPE_LO: begin
          qtype[7:0] = b;
          phase = PH_DONE;
        end
        default: ;
      endcase
      if (pos < 511) pos++;
    endfunction

    function void note_word(func_t f, logic [3:0] idx, logic [5:0] cp, logic [7:0] b,
                            logic [5:0] rl, logic bl, logic [31:0] ad, logic lst);
      verdict_word_t w;
      int n;
      case (f)
        FN_CHAR: txt[idx][cp] = b;
        FN_ATTR: begin
          len[idx] = rl; blk[idx] = bl; redir[idx] = ad;
        end
        FN_BYTE: begin
          take_byte(b);
          if (lst) begin
            w.verdict = V_NONE; w.qid = qid; w.addr = '0;
            if (phase == PH_DONE && qtype == QTYPE_A) begin
              n = (active < RULES_DEF) ? active : RULES_DEF;
              w.verdict = V_NOMATCH;
              for (int r = 0; r < n; r++)
                if (rule_hit(r)) begin
                  if (blk[r]) w.verdict = V_BLOCK;
                  else begin
                    w.verdict = V_REDIRECT;
                    w.addr = redir[r];
                  end
                  break;
                end
            end
            pending.push_back(w);
            clear_packet();
          end
        end
        default: ;
      endcase
    endfunction

    function void check_word(logic [1:0] v, logic [15:0] q, logic [31:0] a);
      verdict_word_t w;
      if (pending.size() == 0) begin
        $error("unexpected verdict word: verdict %0d qid %h", v, q);
        errors++;
        return;
      end
      w = pending.pop_front();
      if (v !== w.verdict) begin
        $error("verdict: expected %0d, got %0d", w.verdict, v);
        errors++;
      end
      if (q !== w.qid) begin
        $error("txn_id: expected %h, got %h", w.qid, q);
        errors++;
      end
      if (a !== w.addr) begin
        $error("answer_addr: expected %h, got %h", w.addr, a);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  dqf_in_if  in_if ();
  dqf_out_if out_if ();
  dqf_cfg_if cfg_if ();

  dns_query_domain_filter uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  verdict_board board = new();
  int   cycles;
  int   sent;          // rule and packet words sent in the random part
  int   text_ok [RULES_DEF];  // written prefix of each rule text
  bit   stall_off;     // stretches with the result side always ready
  localparam int CYCLE_LIMIT = 1500000;

  string label_pool[$] = '{"a", "bc", "com", "ad", "x", "net", "mail"};

  // Monitors: everything is sampled on the rising edge.
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      board.note_word(func_t'(in_if.func), in_if.rule_index, in_if.char_pos,
                      in_if.byte_value, in_if.rule_length, in_if.blocked,
                      in_if.redirect_addr, in_if.last);
    if (rst_n && cfg_if.valid && cfg_if.ready)
      board.active = cfg_if.data;
    if (rst_n && out_if.valid && out_if.ready)
      board.check_word(out_if.verdict, out_if.txn_id, out_if.answer_addr);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Result side back-pressure: mostly short stalls, now and then a long one.
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (stall_off || r < 60) out_if.ready = 1'b1;
    else if (r < 97) out_if.ready = 1'b0;
    else begin
      out_if.ready = 1'b0;
      repeat ($urandom_range(10, 60)) @(negedge clk);
    end
  end

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return;
    in_if.valid = 1'b0;
    if (r < 95) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(10, 50)) @(negedge clk);
  endtask

  // Drives one word, holds it until taken, then leaves the bus at the falling edge.
  task automatic send_word(func_t f, logic [3:0] idx, logic [5:0] cp, logic [7:0] b,
                           logic [5:0] rl, logic bl, logic [31:0] ad, logic lst);
    in_if.valid = 1'b1; in_if.func = f; in_if.rule_index = idx; in_if.char_pos = cp;
    in_if.byte_value = b; in_if.rule_length = rl; in_if.blocked = bl;
    in_if.redirect_addr = ad; in_if.last = lst;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    in_if.valid = 1'b0;
    idle_gap();
  endtask

  task automatic write_rule(int idx, string t, logic bl, logic [31:0] ad);
    for (int i = 0; i < t.len(); i++)
      send_word(FN_CHAR, idx, i, t[i], $urandom, $urandom, $urandom, $urandom);
    if (t.len() > text_ok[idx]) text_ok[idx] = t.len();
    send_word(FN_ATTR, idx, $urandom, $urandom, t.len(), bl, ad, $urandom);
  endtask

  task automatic send_packet(byte_q_t p);
    for (int i = 0; i < p.size(); i++)
      send_word(FN_BYTE, $urandom, $urandom, p[i], $urandom, $urandom, $urandom,
                i == p.size() - 1);
  endtask

  // Builds a query: header, encoded name, type, trailing bytes.
  function automatic byte_q_t build_query(logic [15:0] id, string dotted,
                                          logic [15:0] qtype, int trail);
    byte_q_t p;
    byte_q_t lab;
    p.push_back(id[15:8]); p.push_back(id[7:0]);
    for (int i = 2; i < HDR_BYTES; i++) p.push_back($urandom);
    for (int i = 0; i <= dotted.len(); i++) begin
      if (i == dotted.len() || dotted[i] == ".") begin
        if (lab.size() > 0) begin
          p.push_back(lab.size());
          foreach (lab[k]) p.push_back(lab[k]);
        end
        lab.delete();
      end else lab.push_back(dotted[i]);
    end
    p.push_back(8'd0);
    p.push_back(qtype[15:8]); p.push_back(qtype[7:0]);
    repeat (trail) p.push_back($urandom);
    return p;
  endfunction

  function automatic string rand_name();
    string s;
    s = label_pool[$urandom_range(0, label_pool.size() - 1)];
    repeat ($urandom_range(0, 2))
      s = {s, ".", label_pool[$urandom_range(0, label_pool.size() - 1)]};
    return s;
  endfunction

  task automatic set_active(logic [4:0] n);
    @(negedge clk);
    cfg_if.valid = 1'b1; cfg_if.data = n;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Waits for all verdicts, then lets a possible rule walk drain before a write.
  task automatic wait_idle();
    in_if.valid = 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
  endtask

  task automatic random_word();
    int r;
    int idx;
    int cp;
    string t;
    byte_q_t p;
    r = $urandom_range(0, 99);
    idx = $urandom_range(0, RULES_DEF - 1);
    if (r < 55) begin
      // well-formed query, mostly type A, sometimes with trailing bytes
      p = build_query($urandom, rand_name(), ($urandom_range(0, 9) < 8) ? QTYPE_A : $urandom,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4) : 0);
      send_packet(p);
      sent += p.size();
    end else if (r < 65) begin
      // cut short or random noise packet
      p = build_query($urandom, rand_name(), QTYPE_A, 0);
      if ($urandom_range(0, 1)) p = p[0:$urandom_range(0, p.size() - 2)];
      else foreach (p[k]) if ($urandom_range(0, 7) == 0) p[k] = $urandom;
      send_packet(p);
      sent += p.size();
    end else if (r < 75) begin
      // name with an out-of-range label length
      p = build_query($urandom, rand_name(), QTYPE_A, 0);
      p[HDR_BYTES] = $urandom_range(64, 255);
      send_packet(p);
      sent += p.size();
    end else if (r < 90) begin
      t = rand_name();
      if ($urandom_range(0, 1)) t = {"*.", t};
      if ($urandom_range(0, 9) == 0) t = "*.";
      write_rule(idx, t, $urandom, $urandom);
      sent += t.len() + 1;
    end else if (r < 95) begin
      // single character write, kept inside or just past the written prefix
      cp = (text_ok[idx] < 63) ? $urandom_range(0, text_ok[idx]) : 63;
      send_word(FN_CHAR, idx, cp, $urandom, $urandom, $urandom, $urandom, $urandom);
      if (cp == text_ok[idx] && text_ok[idx] < RULE_CHARS) text_ok[idx]++;
      sent++;
    end else if (r < 98) begin
      send_word(FN_ATTR, idx, $urandom, $urandom,
                $urandom_range(0, (text_ok[idx] < 63) ? text_ok[idx] : 63), $urandom,
                $urandom, $urandom);
      sent++;
    end else begin
      send_word(FN_NONE, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                $urandom);
    end
  endtask

  initial begin
    string long_label;
    string long_rule;
    logic [4:0] settings[4];
    byte_q_t p;
    in_if.valid = 1'b0; in_if.func = FN_NONE; in_if.rule_index = '0; in_if.char_pos = '0;
    in_if.byte_value = '0; in_if.rule_length = '0; in_if.blocked = 1'b0;
    in_if.redirect_addr = '0; in_if.last = 1'b0;
    cfg_if.valid = 1'b0; cfg_if.data = '0;
    out_if.ready = 1'b1;
    board.clear_packet();
    board.active = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    // Every rule gets an empty text first so no walk touches unwritten entries.
    for (int i = 0; i < RULES_DEF; i++) begin
      text_ok[i] = 0;
      send_word(FN_ATTR, i, '0, '0, '0, 1'b1, '0, 1'b0);
    end

    // Directed part: exact, suffix, long rule, the bare suffix rule last.
    write_rule(0, "ab.com", 1'b1, 32'h0);
    write_rule(1, "*.com", 1'b0, 32'hFFFF_FFFF);
    long_rule = "";
    repeat (63) long_rule = {long_rule, "z"};
    write_rule(2, long_rule, 1'b0, 32'hA5A5_0001);
    write_rule(3, "*.", 1'b0, 32'h0102_0304);
    wait_idle();
    set_active(5'd16);
    send_packet(build_query(16'hFFFF, "ab.com", QTYPE_A, 0));        // exact block
    send_packet(build_query(16'h0000, "x.ab.com", QTYPE_A, 0));      // suffix redirect
    send_packet(build_query(16'h1234, "ab.net", QTYPE_A, 2));        // bare suffix, trailer
    send_packet(build_query(16'h4321, "ab.com", 16'd28, 0));         // not type A
    p = build_query(16'h5555, "ab.com", QTYPE_A, 0);
    send_packet(p[0:4]);                                              // short packet
    p = build_query(16'hAAAA, "ab.com", QTYPE_A, 0);
    send_packet(p[0:15]);                                             // cut in the name
    p = build_query(16'h0F0F, "ab.com", QTYPE_A, 0);
    send_packet(p[0:$-1]);                                            // one type byte only
    send_word(FN_BYTE, '0, '0, 8'h7E, '0, 1'b0, '0, 1'b1);            // one-byte packet
    p = build_query(16'h2222, "ab", QTYPE_A, 0);
    p[HDR_BYTES] = 8'd64;                                             // bad label length
    send_packet(p);
    long_label = "";
    repeat (63) long_label = {long_label, "z"};
    send_packet(build_query(16'h3333, long_label, QTYPE_A, 0));       // matches long rule
    send_packet(build_query(16'h3434, {long_label, ".", long_label}, QTYPE_A, 0)); // cut name
    send_word(FN_NONE, 4'hF, 6'h3F, 8'hFF, 6'h3F, 1'b1, 32'hFFFF_FFFF, 1'b1);
    wait_idle();
    set_active(5'd0);
    send_packet(build_query(16'h0101, "ab.com", QTYPE_A, 0));         // no rules checked
    wait_idle();
    set_active(5'd31);
    send_packet(build_query(16'h0202, "ab.com", QTYPE_A, 0));
    wait_idle();
    set_active(5'd1);
    send_packet(build_query(16'h0303, "q.com", QTYPE_A, 0));          // only rule 0: no match

    // Random part in four phases with different active_rules settings.
    settings = '{5'd16, 5'd0, 5'd31, 5'($urandom_range(1, 15))};
    sent = 0;
    foreach (settings[k]) begin
      wait_idle();
      set_active(settings[k]);
      stall_off = (k == 2);
      while (sent < 230 * (k + 1)) random_word();
    end

    wait_idle();
    repeat (200) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("Simulation PASSED");
    else begin
      if (board.pending.size() != 0)
        $error("%0d verdicts never arrived", board.pending.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/dqf_pkg.sv
rtl/dqf_ifs.sv
rtl/dqf_front.sv
rtl/dqf_fifo.sv
rtl/dqf_back.sv
rtl/dns_query_domain_filter.sv
rtl/dqf_checker.sv
dv/testbench.sv
